@@ hw/rtl/edcc_pkg.sv @@
// ----------------------------------------------------------------------------
// edcc_pkg
// Shared widths, codes and calendar helpers of the epoch day calendar
// converter.
// ----------------------------------------------------------------------------
`default_nettype none

package edcc_pkg;

  localparam int OP_W     = 1;
  localparam int COUNT_W  = 17;
  localparam int YEAR_W   = 12;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int STATUS_W = 2;
  localparam int WDAY_W   = 3;
  localparam int WEEK_W   = 6;
  localparam int YLEN_W   = 9;
  localparam int DOY_W    = 9;

  localparam int YEAR_SPAN_DEF = 256;

  localparam logic [OP_W-1:0] OP_TO_DATE  = 1'b0;
  localparam logic [OP_W-1:0] OP_TO_COUNT = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_DATE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_SPAN     = 2'd2;

  localparam int EPOCH_YEAR_INT = 1970;
  localparam logic [YEAR_W-1:0]  EPOCH_YEAR    = 12'd1970;
  localparam logic [WDAY_W-1:0]  EPOCH_WEEKDAY = 3'd4;
  localparam logic [MONTH_W-1:0] MONTH_JAN     = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB     = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_APR     = 4'd4;
  localparam logic [MONTH_W-1:0] MONTH_JUN     = 4'd6;
  localparam logic [MONTH_W-1:0] MONTH_SEP     = 4'd9;
  localparam logic [MONTH_W-1:0] MONTH_NOV     = 4'd11;
  localparam logic [MONTH_W-1:0] MONTH_DEC     = 4'd12;

  // lengths looked up for the current year and month
  typedef struct packed {
    logic              leap;
    logic [YLEN_W-1:0] year_len;
    logic [DAY_W-1:0]  month_len;
  } len_t;

  // divisible by 400, or by 4 and not by 100; y / 25 by reciprocal multiply
  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    logic [24:0] prod;
    logic [7:0]  q25;
    logic        div25;
    prod  = 25'(y) * 25'd5243;
    q25   = prod[24:17];
    div25 = ((12'(q25) * 12'd25) == y);
    return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/edcc_if.sv @@
// ----------------------------------------------------------------------------
// edcc_if
// Valid/ready channels carrying request and result items of the converter.
// ----------------------------------------------------------------------------
`default_nettype none

interface edcc_in_if import edcc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [COUNT_W-1:0] day_count;
  logic [YEAR_W-1:0]  year_in;
  logic [MONTH_W-1:0] month_in;
  logic [DAY_W-1:0]   day_in;

  modport source (output valid, operation, day_count, year_in, month_in, day_in,
                  input ready);
  modport sink   (input valid, operation, day_count, year_in, month_in, day_in,
                  output ready);
endinterface

interface edcc_out_if import edcc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  day_count_out;
  logic [YEAR_W-1:0]   year_out;
  logic [MONTH_W-1:0]  month_out;
  logic [DAY_W-1:0]    day_out;
  logic [WDAY_W-1:0]   weekday;
  logic [WEEK_W-1:0]   week_number;

  modport source (output valid, status, day_count_out, year_out, month_out,
                  day_out, weekday, week_number, input ready);
  modport sink   (input valid, status, day_count_out, year_out, month_out,
                  day_out, weekday, week_number, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/edcc_len.sv @@
// ----------------------------------------------------------------------------
// edcc_len
// Year and month length lookup for the year and month under work.
// ----------------------------------------------------------------------------
`default_nettype none

module edcc_len import edcc_pkg::*; (
  input  logic [YEAR_W-1:0]  year,
  input  logic [MONTH_W-1:0] month,
  output len_t               len
);

  logic leap;

  assign leap = is_leap(year);

  always_comb begin
    len.leap     = leap;
    len.year_len = leap ? 9'd366 : 9'd365;
    if (month == MONTH_FEB) begin
      len.month_len = leap ? 5'd29 : 5'd28;
    end else if (month == MONTH_APR || month == MONTH_JUN ||
                 month == MONTH_SEP || month == MONTH_NOV) begin
      len.month_len = 5'd30;
    end else begin
      len.month_len = 5'd31;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/edcc_alu.sv @@
// ----------------------------------------------------------------------------
// edcc_alu
// Shared add/subtract unit with an unsigned greater-or-equal flag on subtract.
// ----------------------------------------------------------------------------
`default_nettype none

module edcc_alu import edcc_pkg::*; #(
  parameter int W = COUNT_W
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         sub,
  output logic [W-1:0] res,
  output logic         ge
);

  logic [W:0] sum;

  // one adder: a - b is a + ~b + 1, carry out set means no borrow
  assign sum = {1'b0, a} + {1'b0, (sub ? ~b : b)} + (W+1)'(sub);
  assign res = sum[W-1:0];
  assign ge  = sum[W];

endmodule

`default_nettype wire

@@ hw/rtl/epoch_day_calendar_converter.sv @@
// ----------------------------------------------------------------------------
// epoch_day_calendar_converter
// Day count <-> Gregorian date converter, epoch 1970-01-01.
// ----------------------------------------------------------------------------
// One request at a time. Operation 0 walks years then months from the epoch,
// subtracting lengths from the day count in one shared adder, one year or
// month per cycle, then forms the week sum and the result. Operation 1 checks
// the date, then adds year and month lengths up to the given date in the same
// adder, then the day and the year total, the week sum and the result. The
// year-by-year walk through the shared adder sets the rate.
// The input is not ready while a request is in work; a finished result waits
// in the output register while the next request is taken.
`default_nettype none

module epoch_day_calendar_converter import edcc_pkg::*; #(
  parameter int YEAR_SPAN = YEAR_SPAN_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  edcc_in_if.sink      in_ch,
  edcc_out_if.source   out_ch
);

  localparam int SPAN_DAYS_W = $clog2(YEAR_SPAN * 366 + 1);
  localparam int CNT_W = (SPAN_DAYS_W > COUNT_W) ? SPAN_DAYS_W : COUNT_W;
  localparam logic [YEAR_W-1:0] LAST_YEAR = YEAR_W'(EPOCH_YEAR_INT + YEAR_SPAN - 1);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CHECK = 8'b0000_0010,
    S_YEAR  = 8'b0000_0100,
    S_MONTH = 8'b0000_1000,
    S_DAY   = 8'b0001_0000,
    S_TOTAL = 8'b0010_0000,
    S_WEEK  = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_t;

  state_t              state_r, state_nxt;
  logic [OP_W-1:0]     op_r, op_nxt;
  logic [STATUS_W-1:0] err_r, err_nxt;
  logic [CNT_W-1:0]    acc_r, acc_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [DOY_W-1:0]    doy0_r, doy0_nxt;
  logic [WDAY_W-1:0]   jan_r, jan_nxt;
  logic [YEAR_W-1:0]   year_r, year_nxt;
  logic [MONTH_W-1:0]  month_r, month_nxt;
  logic [DAY_W-1:0]    day_r, day_nxt;
  logic [YEAR_W-1:0]   tyear_r, tyear_nxt;
  logic [MONTH_W-1:0]  tmonth_r, tmonth_nxt;
  logic [DOY_W-1:0]    wsum_r, wsum_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [COUNT_W-1:0]  count_out_r, count_out_nxt;
  logic [YEAR_W-1:0]   year_out_r, year_out_nxt;
  logic [MONTH_W-1:0]  month_out_r, month_out_nxt;
  logic [DAY_W-1:0]    day_out_r, day_out_nxt;
  logic [WDAY_W-1:0]   wday_r, wday_nxt;
  logic [WEEK_W-1:0]   week_r, week_nxt;

  len_t                len;
  logic [CNT_W-1:0]    alu_a, alu_b, alu_res;
  logic                alu_sub, alu_ge;
  logic                in_xfer;
  logic                out_free;
  logic [WDAY_W-1:0]   jan_inc;
  logic [WDAY_W:0]     jan_sum;
  logic [WDAY_W-1:0]   jan_step;
  logic [17:0]         wq_prod;
  logic [WEEK_W-1:0]   wq;
  logic [DOY_W-1:0]    wrem;
  logic                date_bad;

  edcc_len u_len (
    .year  (year_r),
    .month (month_r),
    .len   (len)
  );

  edcc_alu #(.W(CNT_W)) u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .res (alu_res),
    .ge  (alu_ge)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  // jan 1 weekday moves by one, or two after a leap year
  assign jan_inc  = len.leap ? 3'd2 : 3'd1;
  assign jan_sum  = {1'b0, jan_r} + {1'b0, jan_inc};
  assign jan_step = (jan_sum >= 4'd7) ? 3'(jan_sum - 4'd7) : jan_sum[WDAY_W-1:0];

  // s / 7 by reciprocal multiply, exact for s <= 371
  assign wq_prod = 18'(wsum_r) * 18'd293;
  assign wq      = wq_prod[16:11];
  assign wrem    = wsum_r - (DOY_W'(wq) * 9'd7);

  assign date_bad = (month_r == 4'd0) || (month_r > MONTH_DEC) || (day_r == 5'd0) ||
                    (year_r < EPOCH_YEAR) || (day_r > len.month_len);

  // operand select for the shared adder
  always_comb begin
    alu_a   = acc_r;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_r)
      S_YEAR: begin
        alu_b   = CNT_W'(len.year_len);
        alu_sub = (op_r == OP_TO_DATE);
      end
      S_MONTH: begin
        alu_b   = CNT_W'(len.month_len);
        alu_sub = (op_r == OP_TO_DATE);
      end
      S_DAY: begin
        alu_b = CNT_W'(day_r - 5'd1);
      end
      S_TOTAL: begin
        alu_a = cnt_r;
        alu_b = CNT_W'(doy0_r);
      end
      default: begin
        alu_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    err_nxt       = err_r;
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    doy0_nxt      = doy0_r;
    jan_nxt       = jan_r;
    year_nxt      = year_r;
    month_nxt     = month_r;
    day_nxt       = day_r;
    tyear_nxt     = tyear_r;
    tmonth_nxt    = tmonth_r;
    wsum_nxt      = wsum_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    status_nxt    = status_r;
    count_out_nxt = count_out_r;
    year_out_nxt  = year_out_r;
    month_out_nxt = month_out_r;
    day_out_nxt   = day_out_r;
    wday_nxt      = wday_r;
    week_nxt      = week_r;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          op_nxt  = in_ch.operation;
          err_nxt = STATUS_OK;
          if (in_ch.operation == OP_TO_DATE) begin
            acc_nxt   = CNT_W'(in_ch.day_count);
            cnt_nxt   = CNT_W'(in_ch.day_count);
            year_nxt  = EPOCH_YEAR;
            month_nxt = MONTH_JAN;
            jan_nxt   = EPOCH_WEEKDAY;
            state_nxt = S_YEAR;
          end else begin
            year_nxt  = in_ch.year_in;
            month_nxt = in_ch.month_in;
            day_nxt   = in_ch.day_in;
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (date_bad) begin
          err_nxt   = STATUS_BAD_DATE;
          state_nxt = S_FIN;
        end else if (year_r > LAST_YEAR) begin
          err_nxt   = STATUS_SPAN;
          state_nxt = S_FIN;
        end else begin
          tyear_nxt  = year_r;
          tmonth_nxt = month_r;
          year_nxt   = EPOCH_YEAR;
          month_nxt  = MONTH_JAN;
          jan_nxt    = EPOCH_WEEKDAY;
          acc_nxt    = '0;
          state_nxt  = S_YEAR;
        end
      end
      S_YEAR: begin
        if (op_r == OP_TO_DATE) begin
          if (alu_ge) begin
            if (year_r >= LAST_YEAR) begin
              err_nxt   = STATUS_SPAN;
              state_nxt = S_FIN;
            end else begin
              acc_nxt  = alu_res;
              year_nxt = year_r + 12'd1;
              jan_nxt  = jan_step;
            end
          end else begin
            doy0_nxt  = acc_r[DOY_W-1:0];
            state_nxt = S_MONTH;
          end
        end else begin
          if (year_r < tyear_r) begin
            acc_nxt  = alu_res;
            year_nxt = year_r + 12'd1;
            jan_nxt  = jan_step;
          end else begin
            cnt_nxt   = acc_r;
            acc_nxt   = '0;
            state_nxt = S_MONTH;
          end
        end
      end
      S_MONTH: begin
        if (op_r == OP_TO_DATE) begin
          if (month_r < MONTH_DEC && alu_ge) begin
            acc_nxt   = alu_res;
            month_nxt = month_r + 4'd1;
          end else begin
            day_nxt   = DAY_W'(acc_r) + 5'd1;
            state_nxt = S_WEEK;
          end
        end else begin
          if (month_r < tmonth_r) begin
            acc_nxt   = alu_res;
            month_nxt = month_r + 4'd1;
          end else begin
            state_nxt = S_DAY;
          end
        end
      end
      S_DAY: begin
        doy0_nxt  = alu_res[DOY_W-1:0];
        state_nxt = S_TOTAL;
      end
      S_TOTAL: begin
        cnt_nxt   = alu_res;
        state_nxt = S_WEEK;
      end
      S_WEEK: begin
        wsum_nxt  = doy0_r + DOY_W'(jan_r);
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          status_nxt    = err_r;
          if (err_r == STATUS_OK) begin
            count_out_nxt = cnt_r[COUNT_W-1:0];
            year_out_nxt  = year_r;
            month_out_nxt = month_r;
            day_out_nxt   = day_r;
            wday_nxt      = wrem[WDAY_W-1:0];
            week_nxt      = wq + 6'd1;
          end else begin
            count_out_nxt = '0;
            year_out_nxt  = '0;
            month_out_nxt = '0;
            day_out_nxt   = '0;
            wday_nxt      = '0;
            week_nxt      = '0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    err_r       <= err_nxt;
    acc_r       <= acc_nxt;
    cnt_r       <= cnt_nxt;
    doy0_r      <= doy0_nxt;
    jan_r       <= jan_nxt;
    year_r      <= year_nxt;
    month_r     <= month_nxt;
    day_r       <= day_nxt;
    tyear_r     <= tyear_nxt;
    tmonth_r    <= tmonth_nxt;
    wsum_r      <= wsum_nxt;
    status_r    <= status_nxt;
    count_out_r <= count_out_nxt;
    year_out_r  <= year_out_nxt;
    month_out_r <= month_out_nxt;
    day_out_r   <= day_out_nxt;
    wday_r      <= wday_nxt;
    week_r      <= week_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = status_r;
  assign out_ch.day_count_out = count_out_r;
  assign out_ch.year_out      = year_out_r;
  assign out_ch.month_out     = month_out_r;
  assign out_ch.day_out       = day_out_r;
  assign out_ch.weekday       = wday_r;
  assign out_ch.week_number   = week_r;

  // a transfer in always starts work
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r != S_IDLE)
    else $error("request taken but sequencer idle");

  // the year walk never leaves the covered span
  a_year_in_span: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_YEAR |-> year_r >= EPOCH_YEAR && year_r <= LAST_YEAR)
    else $error("year walk out of span");

  // the month walk stays within the calendar
  a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MONTH |-> month_r >= MONTH_JAN && month_r <= MONTH_DEC)
    else $error("month walk out of range");

  // a good result always carries a real date
  a_ok_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r == STATUS_OK |->
      month_out_r >= MONTH_JAN && month_out_r <= MONTH_DEC &&
      day_out_r != 5'd0 && wday_r < 3'd7 && week_r != 6'd0)
    else $error("bad fields in good result");

  // a result is not overwritten before its transfer
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r && $stable(status_r) &&
      $stable(count_out_r))
    else $error("pending result lost");

endmodule

`default_nettype wire

@@ dv/epoch_day_calendar_converter_test.sv @@
// ----------------------------------------------------------------------------
// epoch_day_calendar_converter_test
// Self-checking bench for the epoch day calendar converter. A short table of
// calendar corner cases runs first, then random requests under three idling
// patterns, one long result-side stall and a pause to drain. Every result is
// compared field by field against its table row or an in-bench calendar model.
// ----------------------------------------------------------------------------
module epoch_day_calendar_converter_test;
  import edcc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int YEAR_SPAN     = YEAR_SPAN_DEF;
  localparam int LAST_YEAR     = EPOCH_YEAR_INT + YEAR_SPAN - 1;
  localparam int RANDOM_ITEMS  = 600;
  localparam int HOLD_CYCLES   = 2000;
  localparam int TAIL_CYCLES   = YEAR_SPAN + 32;
  localparam int DIRECTED_ROWS = 25;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [COUNT_W-1:0] day_count;
    logic [YEAR_W-1:0]  year_in;
    logic [MONTH_W-1:0] month_in;
    logic [DAY_W-1:0]   day_in;
  } date_request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  day_count_out;
    logic [YEAR_W-1:0]   year_out;
    logic [MONTH_W-1:0]  month_out;
    logic [DAY_W-1:0]    day_out;
    logic [WDAY_W-1:0]   weekday;
    logic [WEEK_W-1:0]   week_number;
  } date_result_t;

  typedef struct packed {
    date_request_t request;
    logic          typed;    // expected result written in the row
    date_result_t  result;
  } directed_row_t;

  localparam date_result_t EPOCH_DAY_RESULT =
    '{STATUS_OK, 17'd0, 12'd1970, 4'd1, 5'd1, 3'd4, 6'd1};
  localparam date_result_t LAST_DAY_RESULT =
    '{STATUS_OK, 17'd93501, 12'd2225, 4'd12, 5'd31, 3'd6, 6'd53};
  localparam date_result_t SPAN_RESULT =
    '{STATUS_SPAN, 17'd0, 12'd0, 4'd0, 5'd0, 3'd0, 6'd0};
  localparam date_result_t BAD_DATE_RESULT =
    '{STATUS_BAD_DATE, 17'd0, 12'd0, 4'd0, 5'd0, 3'd0, 6'd0};

  localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{'{OP_TO_DATE,  17'd0,      12'hfff, 4'hf, 5'h1f}, 1'b1, EPOCH_DAY_RESULT},
    '{'{OP_TO_DATE,  17'd93501,  12'hfff, 4'hf, 5'h1f}, 1'b1, LAST_DAY_RESULT},
    '{'{OP_TO_DATE,  17'd93502,  12'd0,   4'd0, 5'd0},  1'b1, SPAN_RESULT},
    '{'{OP_TO_DATE,  17'd131071, 12'd0,   4'd0, 5'd0},  1'b1, SPAN_RESULT},
    // last day of a leap year that starts on a saturday: week 54
    '{'{OP_TO_DATE,  17'd11322,  12'd0,   4'd0, 5'd0},  1'b0, '0},
    '{'{OP_TO_DATE,  17'd11016,  12'd0,   4'd0, 5'd0},  1'b0, '0},
    '{'{OP_TO_DATE,  17'd65536,  12'd0,   4'd0, 5'd0},  1'b0, '0},
    '{'{OP_TO_COUNT, 17'h1ffff,  12'd1970, 4'd1, 5'd1},  1'b1, EPOCH_DAY_RESULT},
    '{'{OP_TO_COUNT, 17'd0,      12'd2225, 4'd12, 5'd31}, 1'b1, LAST_DAY_RESULT},
    '{'{OP_TO_COUNT, 17'd0,      12'd2226, 4'd1, 5'd1},  1'b1, SPAN_RESULT},
    '{'{OP_TO_COUNT, 17'd0,      12'd4095, 4'd12, 5'd31}, 1'b1, SPAN_RESULT},
    '{'{OP_TO_COUNT, 17'd0,      12'd1969, 4'd12, 5'd31}, 1'b1, BAD_DATE_RESULT},
    '{'{OP_TO_COUNT, 17'd0,      12'd0,    4'd0,  5'd0},  1'b1, BAD_DATE_RESULT},
    '{'{OP_TO_COUNT, 17'h1ffff,  12'd4095, 4'd15, 5'd31}, 1'b1, BAD_DATE_RESULT},
    '{'{OP_TO_COUNT, 17'd0,      12'd2000, 4'd13, 5'd1},  1'b1, BAD_DATE_RESULT},
    '{'{OP_TO_COUNT, 17'd0,      12'd2000, 4'd1,  5'd0},  1'b1, BAD_DATE_RESULT},
    '{'{OP_TO_COUNT, 17'd0,      12'd2000, 4'd2,  5'd29}, 1'b0, '0},
    // century that is not a leap year
    '{'{OP_TO_COUNT, 17'd0,      12'd2100, 4'd2,  5'd29}, 1'b1, BAD_DATE_RESULT},
    '{'{OP_TO_COUNT, 17'd0,      12'd1972, 4'd2,  5'd29}, 1'b0, '0},
    '{'{OP_TO_COUNT, 17'd0,      12'd1971, 4'd2,  5'd29}, 1'b1, BAD_DATE_RESULT},
    '{'{OP_TO_COUNT, 17'd0,      12'd1970, 4'd4,  5'd31}, 1'b1, BAD_DATE_RESULT},
    '{'{OP_TO_COUNT, 17'd0,      12'd2000, 4'd12, 5'd31}, 1'b0, '0},
    '{'{OP_TO_COUNT, 17'd0,      12'd2225, 4'd2,  5'd29}, 1'b1, BAD_DATE_RESULT},
    '{'{OP_TO_COUNT, 17'd0,      12'd2024, 4'd12, 5'd31}, 1'b0, '0},
    '{'{OP_TO_COUNT, 17'd0,      12'd2100, 4'd2,  5'd28}, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst_n;

  edcc_in_if  in_ch ();
  edcc_out_if out_ch ();

  epoch_day_calendar_converter #(
    .YEAR_SPAN(YEAR_SPAN)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  date_result_t expected_dates[$];
  int unsigned  mismatches = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_idle_pct = 0;
  int unsigned  hold_requests = 0;
  int unsigned  last_day_count;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------- calendar

  function automatic logic leap_year(input int unsigned y);
    if (y % 400 == 0) return 1'b1;
    if (y % 100 == 0) return 1'b0;
    return (y % 4 == 0);
  endfunction

  function automatic int unsigned year_days(input int unsigned y);
    return leap_year(y) ? 366 : 365;
  endfunction

  function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
    if (m == MONTH_FEB) return leap_year(y) ? 29 : 28;
    if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV) return 30;
    return 31;
  endfunction

  function automatic int unsigned days_before_year(input int unsigned y);
    int unsigned total;
    total = 0;
    for (int unsigned k = EPOCH_YEAR_INT; k < y; k++) total += year_days(k);
    return total;
  endfunction

  function automatic date_result_t error_result(input logic [STATUS_W-1:0] status);
    date_result_t res;
    res = '0;
    res.status = status;
    return res;
  endfunction

  // returns 0 when the count lies past the last year of the span
  function automatic logic decode_day_count(input int unsigned count,
                                            output date_result_t res);
    int unsigned rem, y, m, doy, jan1_wd;
    rem = count;
    y = EPOCH_YEAR_INT;
    m = 32'(MONTH_JAN);
    res = '0;
    while (rem >= year_days(y)) begin
      if (y >= LAST_YEAR) return 1'b0;
      rem -= year_days(y);
      y++;
    end
    doy = rem + 1;
    while (m < MONTH_DEC && rem >= month_days(m, y)) begin
      rem -= month_days(m, y);
      m++;
    end
    jan1_wd = (count - (doy - 1) + int'(EPOCH_WEEKDAY)) % 7;
    res.status        = STATUS_OK;
    res.day_count_out = COUNT_W'(count);
    res.year_out      = YEAR_W'(y);
    res.month_out     = MONTH_W'(m);
    res.day_out       = DAY_W'(rem + 1);
    res.weekday       = WDAY_W'((count + int'(EPOCH_WEEKDAY)) % 7);
    res.week_number   = WEEK_W'((doy - 1 + jan1_wd) / 7 + 1);
    return 1'b1;
  endfunction

  function automatic date_result_t predict_conversion(input date_request_t req);
    date_result_t res;
    int unsigned  y, m, d, total;
    if (req.operation == OP_TO_DATE) begin
      if (!decode_day_count(32'(req.day_count), res)) res = error_result(STATUS_SPAN);
      return res;
    end
    y = 32'(req.year_in);
    m = 32'(req.month_in);
    d = 32'(req.day_in);
    if (m < MONTH_JAN || m > MONTH_DEC || d == 0 || y < EPOCH_YEAR_INT ||
        d > month_days(m, y)) return error_result(STATUS_BAD_DATE);
    if (y > LAST_YEAR) return error_result(STATUS_SPAN);
    total = days_before_year(y);
    for (int unsigned k = 32'(MONTH_JAN); k < m; k++) total += month_days(k, y);
    total += d - 1;
    if (!decode_day_count(total, res)) res = error_result(STATUS_SPAN);
    res.day_count_out = COUNT_W'(total);
    return res;
  endfunction

  // mostly well-formed requests near the interesting ranges, some raw noise
  function automatic date_request_t random_request();
    date_request_t req;
    int unsigned   pick, y, m;
    pick = $urandom_range(0, 99);
    req.operation = OP_W'($urandom_range(0, 1));
    req.day_count = COUNT_W'($urandom);
    req.year_in   = YEAR_W'($urandom);
    req.month_in  = MONTH_W'($urandom);
    req.day_in    = DAY_W'($urandom);
    if (pick >= 85) return req;
    if (req.operation == OP_TO_DATE) begin
      if (pick < 75) req.day_count = COUNT_W'($urandom_range(0, last_day_count));
      else req.day_count = COUNT_W'($urandom_range(last_day_count - 800,
                                                   last_day_count + 800));
    end else begin
      if (pick < 75) y = $urandom_range(EPOCH_YEAR_INT, LAST_YEAR);
      else if (pick < 80) y = $urandom_range(EPOCH_YEAR_INT, EPOCH_YEAR_INT + 3);
      else y = $urandom_range(LAST_YEAR - 2, LAST_YEAR + 2);
      m = $urandom_range(MONTH_JAN, MONTH_DEC);
      req.year_in  = YEAR_W'(y);
      req.month_in = MONTH_W'(m);
      req.day_in   = DAY_W'($urandom_range(1, month_days(m, y)));
    end
    return req;
  endfunction

  // ---------------------------------------------------------------- request side

  task automatic send_request(input date_request_t req, input date_result_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= req.operation;
    in_ch.day_count <= req.day_count;
    in_ch.year_in   <= req.year_in;
    in_ch.month_in  <= req.month_in;
    in_ch.day_in    <= req.day_in;
    do @(posedge clk); while (!in_ch.ready);
    expected_dates.push_back(want);
  endtask

  task automatic wait_all_results();
    in_ch.valid <= 1'b0;
    while (expected_dates.size() != 0) @(posedge clk);
  endtask

  task automatic random_phase(input int unsigned send_pct, input int unsigned recv_pct);
    date_request_t req;
    send_idle_pct = send_pct;
    recv_idle_pct <= recv_pct;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      req = random_request();
      send_request(req, predict_conversion(req));
    end
  endtask

  initial begin : stimulus
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.operation <= OP_TO_DATE;
    in_ch.day_count <= '0;
    in_ch.year_in   <= '0;
    in_ch.month_in  <= '0;
    in_ch.day_in    <= '0;
    last_day_count = days_before_year(LAST_YEAR + 1) - 1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[i]) begin
      send_request(DIRECTED[i].request, DIRECTED[i].typed ?
                   DIRECTED[i].result : predict_conversion(DIRECTED[i].request));
    end
    wait_all_results();

    random_phase(36, 84);
    wait_all_results();
    random_phase(84, 36);
    wait_all_results();
    // result side stalls long while requests keep coming
    hold_requests <= hold_requests + 1;
    random_phase(0, 0);
    wait_all_results();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("[epoch_day_calendar_converter] OK");
    else $display("[epoch_day_calendar_converter] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------- result side

  initial begin : result_ready
    int unsigned holds_done;
    holds_done = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_done) begin
        holds_done = hold_requests;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic compare_field(input string field_name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field_name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result(input date_result_t got);
    date_result_t want;
    if (expected_dates.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %p", $time, got);
      mismatches++;
      return;
    end
    want = expected_dates.pop_front();
    compare_field("status",        32'(want.status),        32'(got.status));
    compare_field("day_count_out", 32'(want.day_count_out), 32'(got.day_count_out));
    compare_field("year_out",      32'(want.year_out),      32'(got.year_out));
    compare_field("month_out",     32'(want.month_out),     32'(got.month_out));
    compare_field("day_out",       32'(want.day_out),       32'(got.day_out));
    compare_field("weekday",       32'(want.weekday),       32'(got.weekday));
    compare_field("week_number",   32'(want.week_number),   32'(got.week_number));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      check_result({out_ch.status, out_ch.day_count_out, out_ch.year_out, out_ch.month_out,
                    out_ch.day_out, out_ch.weekday, out_ch.week_number});
    end
  end

  initial begin : watchdog
    #30ms;
    $display("[epoch_day_calendar_converter] ERROR");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/edcc_pkg.sv
hw/rtl/edcc_if.sv
hw/rtl/edcc_len.sv
hw/rtl/edcc_alu.sv
hw/rtl/epoch_day_calendar_converter.sv
dv/epoch_day_calendar_converter_test.sv
